// ===== design/stop_and_wait_sender_adaptive_rto_assert.svh =====
// assertion helpers for the stop-and-wait sender
`ifndef STOP_AND_WAIT_SENDER_ADAPTIVE_RTO_ASSERT_SVH
`define STOP_AND_WAIT_SENDER_ADAPTIVE_RTO_ASSERT_SVH

// same-cycle property under clk_i, off while in reset
`define SWART_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// next-cycle implication under clk_i, off while in reset
`define SWART_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== design/swart_pkg.sv =====
`timescale 1ns / 1ps
package swart_pkg;

  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACK   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_TMO   = 2'd2;

  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_END   = 3'd1;
  localparam logic [2:0] KIND_ABORT = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_UNACK = 3'd4;

  localparam logic [1:0] SEQ_END = 2'd2;

  localparam logic [31:0] US_PER_MS = 32'd1000;

  // divide-by-ten unit: dividend width
  localparam int DIV_W = 36;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DATA,
    PH_END
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEND,
    S_PUSH,
    S_SHIFT,
    S_SHIFTW,
    S_SRCH,
    S_SRCHC,
    S_MUL,
    S_DIV1,
    S_SCALE,
    S_DIV2,
    S_ADV,
    S_EMIT
  } state_e;

endpackage

// ===== design/swart_ram.sv =====
`timescale 1ns / 1ps
module swart_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/swart_div10.sv =====
`timescale 1ns / 1ps
module swart_div10 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [swart_pkg::DIV_W-1:0] num_i,
  output logic                       done_o,
  output logic [swart_pkg::DIV_W-1:0] quot_o
);
  import swart_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [2:0]       step_q, step_d;
  logic [DIV_W-1:0] num_q, num_d;
  logic [DIV_W-1:0] quot_q, quot_d;

  // n * 0.8 by shift-add, then >> 3 gives n / 10 low by at most one;
  // the remainder check fixes that up
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d  = num_i;
      quot_d = '0;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      case (step_q)
        3'd0: quot_d = (num_q >> 1) + (num_q >> 2);
        3'd1: quot_d = quot_q + (quot_q >> 4);
        3'd2: quot_d = quot_q + (quot_q >> 8);
        3'd3: quot_d = quot_q + (quot_q >> 16);
        3'd4: quot_d = quot_q + (quot_q >> 32);
        3'd5: quot_d = quot_q >> 3;
        // remainder kept in place of the dividend
        3'd6: num_d = num_q - ((quot_q << 3) + (quot_q << 1));
        3'd7: begin
          quot_d = quot_q + ((num_q > DIV_W'(9)) ? DIV_W'(1) : DIV_W'(0));
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      num_q  <= '0;
      quot_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      num_q  <= num_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== design/stop_and_wait_sender_adaptive_rto.sv =====
`timescale 1ns / 1ps
// Stop-and-wait sender with an adaptive retransmit timeout.
// Config: write file_size, block_size and initial_timeout_ms through cfg_we_i,
// cfg_idx_i, cfg_data_i while the sender has no command in flight.
// Input channel (in_valid_i / in_stall_o) takes one command per beat: start,
// one microsecond tick, or ack with the echoed stamp in ack_stamp_i.
// Output channel (out_valid_o / out_stall_i) gives at most one result beat per
// command: a data block, the end marker, abort, done or end unacked.
// A start or a resend passes S_SEND and S_PUSH before S_EMIT loads the result
// beat (the end marker skips S_PUSH); abort and done go straight to S_EMIT; a
// tick that does not time out or an ignored command gives no beat and frees
// the input at once. A send that finds the stamp store full drops the oldest
// stamp first by shifting the store down. An ack scans the store one entry at
// a time through the registered RAM read; a match shifts later entries down
// and runs two divide-by-ten passes before the next block is sent.
// A finished result sits in the output register until taken; while the
// receiver stalls and a new result is ready, the sender holds in_stall_o high.
// Reset clears the clock, the timer, the phase and the stamp store fill count;
// the stamp RAM needs no clearing.
module stop_and_wait_sender_adaptive_rto #(
  parameter int PENDING_DEPTH = 8,
  parameter int MAX_BLOCK     = 1471,
  parameter int RETRY_LIMIT   = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swart_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [swart_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [swart_pkg::CMD_W-1:0]     cmd_i,
  input  logic [31:0]                    ack_stamp_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     kind_o,
  output logic [1:0]                     seq_o,
  output logic [23:0]                    offset_o,
  output logic [10:0]                    length_o,
  output logic [31:0]                    stamp_o,
  output logic [31:0]                    rto_o
);
  import swart_pkg::*;

  localparam int AW = $clog2(PENDING_DEPTH);
  localparam int CW = $clog2(PENDING_DEPTH + 1);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [23:0]    fs_q, fs_d;
  logic [10:0]    bs_q, bs_d;
  logic [21:0]    ims_q, ims_d;
  logic [31:0]    now_q, now_d;
  logic [31:0]    timer_q, timer_d;
  logic [31:0]    tmo_q, tmo_d;
  logic [31:0]    est_q, est_d;
  logic [1:0]     scnt_q, scnt_d;
  logic           alt_q, alt_d;
  logic [23:0]    off_q, off_d;
  logic [CW-1:0]  pcnt_q, pcnt_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [31:0]    ack_q, ack_d;
  logic [31:0]    sample_q, sample_d;
  logic           sel_next_q, sel_next_d;
  logic           push_after_q, push_after_d;

  logic [2:0]     rk_q, rk_d;
  logic [1:0]     rs_q, rs_d;
  logic [23:0]    ro_q, ro_d;
  logic [10:0]    rl_q, rl_d;
  logic [31:0]    rstamp_q, rstamp_d;
  logic [31:0]    rrto_q, rrto_d;

  logic           ovalid_q, ovalid_d;
  logic [2:0]     okind_q, okind_d;
  logic [1:0]     oseq_q, oseq_d;
  logic [23:0]    ooff_q, ooff_d;
  logic [10:0]    olen_q, olen_d;
  logic [31:0]    ostamp_q, ostamp_d;
  logic [31:0]    orto_q, orto_d;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [31:0]    ram_wdata, ram_rdata;

  logic           div_start, div_done;
  logic [DIV_W-1:0] div_num, div_quot;

  logic [10:0]    bs_eff;
  logic [23:0]    rem;
  logic [10:0]    curlen;
  logic [31:0]    tmo_fix;
  logic [31:0]    timer_dec;
  logic           send_end;
  logic [CW-1:0]  idx_p1;
  logic           tick_fire;
  logic           out_free;
  logic           match;

  swart_ram #(.WIDTH(32), .DEPTH(PENDING_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  swart_div10 u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    if (bs_q == '0) begin
      bs_eff = 11'd1;
    end else if (bs_q > 11'(MAX_BLOCK)) begin
      bs_eff = 11'(MAX_BLOCK);
    end else begin
      bs_eff = bs_q;
    end
    rem       = (fs_q > off_q) ? fs_q - off_q : '0;
    curlen    = (rem < {13'd0, bs_eff}) ? rem[10:0] : bs_eff;
    tmo_fix   = (tmo_q == '0) ? 32'd1 : tmo_q;
    timer_dec = timer_q - 32'd1;
    send_end  = sel_next_q ? (off_q >= fs_q) : (phase_q == PH_END);
    idx_p1    = idx_q + CW'(1);
    tick_fire = (phase_q != PH_IDLE) && (timer_q != '0) && (timer_dec == '0);
    out_free  = !ovalid_q || !out_stall_i;
    match     = (ram_rdata == ack_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (cmd_i)
            CMD_START: state_d = S_SEND;
            CMD_TICK: begin
              if (tick_fire) begin
                state_d = (scnt_q >= 2'(RETRY_LIMIT)) ? S_EMIT : S_SEND;
              end
            end
            CMD_ACK: begin
              if (phase_q == PH_END) begin
                state_d = S_EMIT;
              end else if (phase_q == PH_DATA) begin
                state_d = S_SRCH;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SEND: begin
        if (send_end) begin
          state_d = S_EMIT;
        end else if (pcnt_q == CW'(PENDING_DEPTH)) begin
          state_d = S_SHIFT;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH:   state_d = S_EMIT;
      S_SHIFT: begin
        if (idx_p1 < pcnt_q) begin
          state_d = S_SHIFTW;
        end else begin
          state_d = push_after_q ? S_PUSH : S_MUL;
        end
      end
      S_SHIFTW: state_d = S_SHIFT;
      S_SRCH:   state_d = (idx_q < pcnt_q) ? S_SRCHC : S_ADV;
      S_SRCHC:  state_d = match ? S_SHIFT : S_SRCH;
      S_MUL:    state_d = S_DIV1;
      S_DIV1:   state_d = div_done ? S_SCALE : S_DIV1;
      S_SCALE:  state_d = S_DIV2;
      S_DIV2:   state_d = div_done ? S_ADV : S_DIV2;
      S_ADV:    state_d = S_SEND;
      S_EMIT:   state_d = out_free ? S_IDLE : S_EMIT;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs toward the RAM and the divider
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    ram_we     = 1'b0;
    ram_waddr  = idx_q[AW-1:0];
    ram_wdata  = ram_rdata;
    ram_raddr  = idx_p1[AW-1:0];
    div_start  = 1'b0;
    div_num    = '0;
    case (state_q)
      S_SRCH:   ram_raddr = idx_q[AW-1:0];
      S_SHIFTW: ram_we = 1'b1;
      S_PUSH: begin
        ram_we    = 1'b1;
        ram_waddr = pcnt_q[AW-1:0];
        ram_wdata = now_q;
      end
      S_MUL: begin
        div_start = 1'b1;
        // 7 * estimate + 3 * sample
        div_num   = ({4'd0, est_q} << 3) - {4'd0, est_q}
                  + ({4'd0, sample_q} << 1) + {4'd0, sample_q};
      end
      S_SCALE: begin
        div_start = 1'b1;
        div_num   = ({4'd0, est_q} << 3) + ({4'd0, est_q} << 2);
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    phase_d      = phase_q;
    fs_d         = fs_q;
    bs_d         = bs_q;
    ims_d        = ims_q;
    now_d        = now_q;
    timer_d      = timer_q;
    tmo_d        = tmo_q;
    est_d        = est_q;
    scnt_d       = scnt_q;
    alt_d        = alt_q;
    off_d        = off_q;
    pcnt_d       = pcnt_q;
    idx_d        = idx_q;
    ack_d        = ack_q;
    sample_d     = sample_q;
    sel_next_d   = sel_next_q;
    push_after_d = push_after_q;
    rk_d         = rk_q;
    rs_d         = rs_q;
    ro_d         = ro_q;
    rl_d         = rl_q;
    rstamp_d     = rstamp_q;
    rrto_d       = rrto_q;
    ovalid_d     = ovalid_q && out_stall_i;
    okind_d      = okind_q;
    oseq_d       = oseq_q;
    ooff_d       = ooff_q;
    olen_d       = olen_q;
    ostamp_d     = ostamp_q;
    orto_d       = orto_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FILE_SIZE:  fs_d  = cfg_data_i;
        REG_BLOCK_SIZE: bs_d  = cfg_data_i[10:0];
        REG_INIT_TMO:   ims_d = cfg_data_i[21:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ack_d = ack_stamp_i;
          case (cmd_i)
            CMD_START: begin
              tmo_d      = {10'd0, ims_q} * US_PER_MS;
              est_d      = {10'd0, ims_q} * US_PER_MS;
              scnt_d     = '0;
              alt_d      = 1'b0;
              off_d      = '0;
              pcnt_d     = '0;
              sel_next_d = 1'b1;
            end
            CMD_TICK: begin
              now_d = now_q + 32'd1;
              if (phase_q != PH_IDLE && timer_q != '0) begin
                timer_d = timer_dec;
              end
              if (tick_fire) begin
                if (scnt_q >= 2'(RETRY_LIMIT)) begin
                  phase_d  = PH_IDLE;
                  rk_d     = (phase_q == PH_DATA) ? KIND_ABORT : KIND_UNACK;
                  rs_d     = '0;
                  ro_d     = '0;
                  rl_d     = '0;
                  rstamp_d = '0;
                  rrto_d   = tmo_q;
                end else begin
                  scnt_d     = scnt_q + 2'd1;
                  sel_next_d = 1'b0;
                end
              end
            end
            CMD_ACK: begin
              if (phase_q == PH_END) begin
                phase_d  = PH_IDLE;
                timer_d  = '0;
                rk_d     = KIND_DONE;
                rs_d     = '0;
                ro_d     = '0;
                rl_d     = '0;
                rstamp_d = '0;
                rrto_d   = tmo_q;
              end else if (phase_q == PH_DATA) begin
                idx_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEND: begin
        tmo_d    = tmo_fix;
        timer_d  = tmo_fix;
        rrto_d   = tmo_fix;
        rstamp_d = now_q;
        ro_d     = off_q;
        if (send_end) begin
          phase_d = PH_END;
          rk_d    = KIND_END;
          rs_d    = SEQ_END;
          rl_d    = '0;
        end else begin
          phase_d = PH_DATA;
          rk_d    = KIND_DATA;
          rs_d    = {1'b0, alt_q};
          rl_d    = curlen;
          // store full: drop the oldest stamp first
          if (pcnt_q == CW'(PENDING_DEPTH)) begin
            idx_d        = '0;
            push_after_d = 1'b1;
          end
        end
      end
      S_PUSH:   pcnt_d = pcnt_q + CW'(1);
      S_SHIFT: begin
        if (!(idx_p1 < pcnt_q)) begin
          pcnt_d = pcnt_q - CW'(1);
        end
      end
      S_SHIFTW: idx_d = idx_p1;
      S_SRCHC: begin
        if (match) begin
          sample_d     = now_q - ram_rdata;
          push_after_d = 1'b0;
        end else begin
          idx_d = idx_p1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          est_d = div_quot[31:0];
        end
      end
      S_DIV2: begin
        if (div_done) begin
          if (div_quot[DIV_W-1:32] != '0) begin
            tmo_d = '1;
          end else if (div_quot[31:0] == '0) begin
            tmo_d = 32'd1;
          end else begin
            tmo_d = div_quot[31:0];
          end
        end
      end
      S_ADV: begin
        scnt_d     = '0;
        off_d      = off_q + {13'd0, curlen};
        alt_d      = !alt_q;
        sel_next_d = 1'b1;
      end
      S_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = rk_q;
          oseq_d   = rs_q;
          ooff_d   = ro_q;
          olen_d   = rl_q;
          ostamp_d = rstamp_q;
          orto_d   = rrto_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_IDLE;
      fs_q         <= '0;
      bs_q         <= 11'd1024;
      ims_q        <= 22'd1000;
      now_q        <= '0;
      timer_q      <= '0;
      tmo_q        <= '0;
      est_q        <= '0;
      scnt_q       <= '0;
      alt_q        <= 1'b0;
      off_q        <= '0;
      pcnt_q       <= '0;
      idx_q        <= '0;
      sel_next_q   <= 1'b1;
      push_after_q <= 1'b0;
      ovalid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      fs_q         <= fs_d;
      bs_q         <= bs_d;
      ims_q        <= ims_d;
      now_q        <= now_d;
      timer_q      <= timer_d;
      tmo_q        <= tmo_d;
      est_q        <= est_d;
      scnt_q       <= scnt_d;
      alt_q        <= alt_d;
      off_q        <= off_d;
      pcnt_q       <= pcnt_d;
      idx_q        <= idx_d;
      sel_next_q   <= sel_next_d;
      push_after_q <= push_after_d;
      ovalid_q     <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ack_q    <= ack_d;
    sample_q <= sample_d;
    rk_q     <= rk_d;
    rs_q     <= rs_d;
    ro_q     <= ro_d;
    rl_q     <= rl_d;
    rstamp_q <= rstamp_d;
    rrto_q   <= rrto_d;
    okind_q  <= okind_d;
    oseq_q   <= oseq_d;
    ooff_q   <= ooff_d;
    olen_q   <= olen_d;
    ostamp_q <= ostamp_d;
    orto_q   <= orto_d;
  end

  assign out_valid_o = ovalid_q;
  assign kind_o      = okind_q;
  assign seq_o       = oseq_q;
  assign offset_o    = ooff_q;
  assign length_o    = olen_q;
  assign stamp_o     = ostamp_q;
  assign rto_o       = orto_q;

endmodule

// ===== design/swart_chk.sv =====
`timescale 1ns / 1ps
`include "stop_and_wait_sender_adaptive_rto_assert.svh"
module swart_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [swart_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [swart_pkg::CFG_W-1:0]     cfg_data_i,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [swart_pkg::CMD_W-1:0]     cmd_i,
  input logic [31:0]                    ack_stamp_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [2:0]                     kind_o,
  input logic [1:0]                     seq_o,
  input logic [23:0]                    offset_o,
  input logic [10:0]                    length_o,
  input logic [31:0]                    stamp_o,
  input logic [31:0]                    rto_o
);
  import swart_pkg::*;

  `SWART_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(kind_o) && $stable(stamp_o))
  // a resend after the file shrank may carry a zero length
  `SWART_ASSERT(a_data_beat, (out_valid_o && kind_o == KIND_DATA) |-> (seq_o != SEQ_END && rto_o != '0))
  `SWART_ASSERT(a_end_beat, (out_valid_o && kind_o == KIND_END) |-> (seq_o == SEQ_END && length_o == '0 && rto_o != '0))
  `SWART_ASSERT(a_final_beat, (out_valid_o && (kind_o == KIND_ABORT || kind_o == KIND_DONE || kind_o == KIND_UNACK)) |-> (seq_o == '0 && offset_o == '0 && stamp_o == '0))

endmodule

bind stop_and_wait_sender_adaptive_rto swart_chk u_swart_chk (.*);
